FILE: rtl/core/command_line_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

FILE: rtl/core/clt_pkg.sv
package clt_pkg;

  localparam int MaxResults = 4;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int QueueDepth = 4;

  localparam logic [7:0] ChAmp = 8'h26;
  localparam logic [7:0] ChDq  = 8'h22;
  localparam logic [7:0] ChSq  = 8'h27;
  localparam logic [7:0] ChBsl = 8'h5C;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_DQUOTE,
    MODE_SQUOTE
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_END,
    KIND_ERROR,
    KIND_DONE
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] token_byte;
    logic       end_of_line;
  } out_item_t;

  // All requests that one input byte produces, oldest in entry zero.
  typedef struct packed {
    logic [CntW-1:0]                   cnt;
    out_item_t [MaxResults-1:0]        res;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic out_item_t mk_item(kind_t k, logic [7:0] c);
    out_item_t item;
    item.kind        = k;
    item.token_byte  = (k == KIND_BYTE) ? c : 8'h00;
    item.end_of_line = (k == KIND_DONE);
    return item;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

FILE: rtl/core/clt_front.sv
module clt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  clt_pkg::in_item_t  in_data,
  output logic               plan_push,
  output clt_pkg::plan_t     plan
);

  clt_pkg::scan_mode_t mode_r, mode_nxt, mode_mid;
  logic                pbs_r, pbs_nxt, pbs_mid;
  logic                esc_r, esc_nxt, esc_mid;
  logic [7:0]          c;
  logic                blank;

  assign c     = in_data.byte_in;
  assign blank = clt_pkg::is_blank(c);

  // Next state after the byte itself, then the line end returns to reset.
  always_comb begin
    mode_mid = mode_r;
    pbs_mid  = pbs_r;
    esc_mid  = esc_r;
    case (mode_r)
      clt_pkg::MODE_IDLE: begin
        if (blank) begin
          mode_mid = clt_pkg::MODE_IDLE;
        end else if (c == clt_pkg::ChDq) begin
          mode_mid = clt_pkg::MODE_DQUOTE;
          pbs_mid  = 1'b0;
        end else if (c == clt_pkg::ChSq) begin
          mode_mid = clt_pkg::MODE_SQUOTE;
        end else if (c == clt_pkg::ChAmp) begin
          mode_mid = clt_pkg::MODE_IDLE;
        end else begin
          mode_mid = clt_pkg::MODE_WORD;
          esc_mid  = (c == clt_pkg::ChBsl);
        end
      end
      clt_pkg::MODE_WORD: begin
        if (esc_r) begin
          esc_mid = 1'b0;
        end else if (blank || (c == clt_pkg::ChAmp)) begin
          mode_mid = clt_pkg::MODE_IDLE;
        end else begin
          esc_mid = (c == clt_pkg::ChBsl);
        end
      end
      clt_pkg::MODE_DQUOTE: begin
        if ((c == clt_pkg::ChDq) && !pbs_r) begin
          mode_mid = clt_pkg::MODE_IDLE;
          pbs_mid  = 1'b0;
        end else begin
          pbs_mid = (c == clt_pkg::ChBsl);
        end
      end
      default: begin
        if (c == clt_pkg::ChSq) begin
          mode_mid = clt_pkg::MODE_IDLE;
        end
      end
    endcase
    if (in_data.line_end) begin
      mode_nxt = clt_pkg::MODE_IDLE;
      pbs_nxt  = 1'b0;
      esc_nxt  = 1'b0;
    end else begin
      mode_nxt = mode_mid;
      pbs_nxt  = pbs_mid;
      esc_nxt  = esc_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= clt_pkg::MODE_IDLE;
      pbs_r  <= 1'b0;
      esc_r  <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pbs_r  <= pbs_nxt;
      esc_r  <= esc_nxt;
    end
  end

  // Requests produced by the byte, in order.
  always_comb begin
    logic [clt_pkg::CntW-1:0] n;
    n    = '0;
    plan = '0;
    case (mode_r)
      clt_pkg::MODE_IDLE: begin
        if (blank || (c == clt_pkg::ChDq) || (c == clt_pkg::ChSq)) begin
          n = '0;
        end else if (c == clt_pkg::ChAmp) begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
          plan.res[1] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
          n = clt_pkg::CntW'(2);
        end else begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
          n = clt_pkg::CntW'(1);
        end
      end
      clt_pkg::MODE_WORD: begin
        if (esc_r) begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
          n = clt_pkg::CntW'(1);
        end else if (blank) begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
          n = clt_pkg::CntW'(1);
        end else if (c == clt_pkg::ChAmp) begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
          plan.res[1] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
          plan.res[2] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
          n = clt_pkg::CntW'(3);
        end else begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
          n = clt_pkg::CntW'(1);
        end
      end
      clt_pkg::MODE_DQUOTE: begin
        if ((c == clt_pkg::ChDq) && !pbs_r) begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
        end else begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
        end
        n = clt_pkg::CntW'(1);
      end
      default: begin
        if (c == clt_pkg::ChSq) begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
        end else begin
          plan.res[0] = clt_pkg::mk_item(clt_pkg::KIND_BYTE, c);
        end
        n = clt_pkg::CntW'(1);
      end
    endcase
    if (in_data.line_end) begin
      if (mode_mid == clt_pkg::MODE_WORD) begin
        plan.res[n[1:0]] = clt_pkg::mk_item(clt_pkg::KIND_END, c);
        n = n + clt_pkg::CntW'(1);
      end else if ((mode_mid == clt_pkg::MODE_DQUOTE) || (mode_mid == clt_pkg::MODE_SQUOTE)) begin
        plan.res[n[1:0]] = clt_pkg::mk_item(clt_pkg::KIND_ERROR, c);
        n = n + clt_pkg::CntW'(1);
      end
      plan.res[n[1:0]] = clt_pkg::mk_item(clt_pkg::KIND_DONE, c);
      n = n + clt_pkg::CntW'(1);
    end
    plan.cnt  = n;
    plan_push = take && (n != '0);
  end

endmodule

FILE: rtl/core/clt_queue.sv
module clt_queue #(
  parameter int DEPTH = clt_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  clt_pkg::plan_t       wr_data,
  input  logic                 pop,
  output clt_pkg::plan_t       rd_data,
  output clt_pkg::q_status_t   status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntQ = $clog2(DEPTH + 1);

  clt_pkg::plan_t  mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntQ-1:0] count_r;
  logic            do_push, do_pop;

  assign status.full  = (count_r == CntQ'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_data      = mem[rd_ptr_r];

  function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntQ'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntQ'(1);
      end
    end
  end

endmodule

FILE: rtl/core/clt_back.sv
module clt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clt_pkg::q_status_t   q_status,
  input  clt_pkg::plan_t       q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output clt_pkg::out_item_t   out_data
);

  logic           busy_r;
  clt_pkg::plan_t cur_r;
  logic [1:0]     idx_r;
  logic           last;
  logic           load;

  assign out_empty = !busy_r;
  assign out_data  = cur_r.res[idx_r];
  assign last      = ((clt_pkg::CntW'(idx_r) + clt_pkg::CntW'(1)) == cur_r.cnt);
  assign load      = !busy_r || (out_pop && last);
  assign q_pop     = load && !q_status.empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= !q_status.empty;
      idx_r  <= '0;
    end else if (out_pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

FILE: rtl/core/command_line_tokenizer.sv
// Command line tokenizer: takes one line byte by byte and streams out its tokens.
// Input queue port: in_data carries byte_in and line_end; it is taken on a clock
// edge with in_push high and in_full low. Set line_end on the last byte of a line.
// Result queue port: out_data carries kind, token_byte and end_of_line; the oldest
// request sits there while out_empty is low and leaves on an edge with out_pop high.
// A line's results end with one line-done request that has end_of_line set.
// A byte's plan is written into the plan queue, then loaded into the output stage.
// One byte is taken per cycle while in_full is low. Bytes that yield nothing pass
// without using the output stage; a byte that yields k requests holds that stage
// until all k are popped (at most four). A queue of QUEUE_DEPTH byte plans sits
// between the classifier and the output stage, so the result side sets the sustained rate.
// When the receiver stalls, the plan queue fills and in_full rises; nothing is lost.
// Synchronous reset clears the scan state, the plan queue and the output stage.
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer #(
  parameter int QUEUE_DEPTH = clt_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  clt_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output clt_pkg::out_item_t out_data
);

  logic               take;
  logic               plan_push;
  clt_pkg::plan_t     plan;
  clt_pkg::plan_t     q_head;
  clt_pkg::q_status_t q_status;
  logic               q_pop;
  logic               out_is_done;
  logic               out_is_byte;

  assign in_full = q_status.full;
  assign take    = in_push && !q_status.full;

  assign out_is_done = (out_data.kind == clt_pkg::KIND_DONE);
  assign out_is_byte = (out_data.kind == clt_pkg::KIND_BYTE);

  clt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_data   (in_data),
    .plan_push (plan_push),
    .plan      (plan)
  );

  clt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (plan_push),
    .wr_data (plan),
    .pop     (q_pop),
    .rd_data (q_head),
    .status  (q_status)
  );

  clt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  `CLT_ASSERT_NOW(a_eol_on_done, clk, rst_n, !out_empty, out_data.end_of_line == out_is_done)
  `CLT_ASSERT_NOW(a_byte_only_in_data, clk, rst_n, !out_empty && !out_is_byte, out_data.token_byte == 8'h00)
  `CLT_ASSERT_NOW(a_queue_status, clk, rst_n, q_status.full, !q_status.empty)
  `CLT_ASSERT_NEXT(a_plan_reaches_back, clk, rst_n, q_pop, !out_empty)

endmodule

FILE: dv/command_line_tokenizer_checker.sv
`timescale 1ns / 100ps

module command_line_tokenizer_checker
  import clt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_data,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_data,
  output int        fail_count,
  output int        waiting
);

  out_item_t  token_stream[$];
  scan_mode_t mode;
  logic       dq_after_bsl;
  logic       literal_next;
  int         mismatches;
  out_item_t  want;

  function automatic logic is_space_char(logic [7:0] c);
    case (c)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit_byte(logic [7:0] c);
    out_item_t r;
    r.kind        = KIND_BYTE;
    r.token_byte  = c;
    r.end_of_line = 1'b0;
    token_stream.push_back(r);
  endtask

  task automatic emit_mark(kind_t k);
    out_item_t r;
    r.kind        = k;
    r.token_byte  = 8'h00;
    r.end_of_line = (k == KIND_DONE);
    token_stream.push_back(r);
  endtask

  task automatic tokenize_byte(in_item_t it);
    logic [7:0] c;
    c = it.byte_in;
    case (mode)
      MODE_IDLE: begin
        if (is_space_char(c)) begin
        end else if (c == ChDq) begin
          mode         = MODE_DQUOTE;
          dq_after_bsl = 1'b0;
        end else if (c == ChSq) begin
          mode = MODE_SQUOTE;
        end else if (c == ChAmp) begin
          emit_byte(c);
          emit_mark(KIND_END);
        end else begin
          mode         = MODE_WORD;
          literal_next = (c == ChBsl);
          emit_byte(c);
        end
      end
      MODE_WORD: begin
        if (literal_next) begin
          literal_next = 1'b0;
          emit_byte(c);
        end else if (is_space_char(c)) begin
          emit_mark(KIND_END);
          mode = MODE_IDLE;
        end else if (c == ChAmp) begin
          emit_mark(KIND_END);
          emit_byte(c);
          emit_mark(KIND_END);
          mode = MODE_IDLE;
        end else begin
          literal_next = (c == ChBsl);
          emit_byte(c);
        end
      end
      MODE_DQUOTE: begin
        if (c == ChDq && !dq_after_bsl) begin
          emit_mark(KIND_END);
          mode         = MODE_IDLE;
          dq_after_bsl = 1'b0;
        end else begin
          emit_byte(c);
          dq_after_bsl = (c == ChBsl);
        end
      end
      default: begin
        if (c == ChSq) begin
          emit_mark(KIND_END);
          mode = MODE_IDLE;
        end else begin
          emit_byte(c);
        end
      end
    endcase
    if (it.line_end) begin
      if (mode == MODE_WORD) begin
        emit_mark(KIND_END);
      end else if (mode == MODE_DQUOTE || mode == MODE_SQUOTE) begin
        emit_mark(KIND_ERROR);
      end
      emit_mark(KIND_DONE);
      mode         = MODE_IDLE;
      dq_after_bsl = 1'b0;
      literal_next = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      token_stream.delete();
      mode         = MODE_IDLE;
      dq_after_bsl = 1'b0;
      literal_next = 1'b0;
      mismatches   = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (token_stream.size() == 0) begin
          mismatches++;
          $display("%0t: expected no request, got kind %0d byte %h eol %b",
                   $time, out_data.kind, out_data.token_byte, out_data.end_of_line);
        end else begin
          want = token_stream.pop_front();
          if (out_data.kind !== want.kind) begin
            mismatches++;
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, out_data.kind);
          end
          if (out_data.token_byte !== want.token_byte) begin
            mismatches++;
            $display("%0t: token_byte expected %h, got %h",
                     $time, want.token_byte, out_data.token_byte);
          end
          if (out_data.end_of_line !== want.end_of_line) begin
            mismatches++;
            $display("%0t: end_of_line expected %b, got %b",
                     $time, want.end_of_line, out_data.end_of_line);
          end
        end
      end
      if (in_push && !in_full) begin
        tokenize_byte(in_data);
      end
    end
    fail_count <= mismatches;
    waiting    <= token_stream.size();
  end

endmodule

FILE: dv/command_line_tokenizer_tb.sv
`timescale 1ns / 100ps

module command_line_tokenizer_tb;
  import clt_pkg::*;

  localparam int         ItemTarget = 220;
  localparam logic [7:0] SpaceCh    = 8'h20;
  localparam logic [7:0] LetterA    = 8'h61;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_push  = 1'b0;
  in_item_t  in_data  = '0;
  logic      out_pop  = 1'b0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_data;
  int        fail_count;
  int        waiting;

  logic [7:0]  line_buf[$];
  int unsigned bytes_sent = 0;

  always #5 clk = ~clk;

  command_line_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  command_line_tokenizer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? SpaceCh : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] letter_char();
    return LetterA + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 11))
      0, 1:    return blank_char();
      2:       return ChDq;
      3:       return ChSq;
      4:       return ChAmp;
      5:       return ChBsl;
      6, 7, 8: return letter_char();
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic add_word();
    int unsigned len;
    len = $urandom_range(1, 5);
    repeat (len) begin
      if ($urandom_range(0, 4) == 0) begin
        line_buf.push_back(ChBsl);
        line_buf.push_back(any_char());
      end else begin
        line_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                       : letter_char());
      end
    end
  endtask

  task automatic add_quoted(logic [7:0] q);
    int unsigned len;
    len = $urandom_range(0, 4);
    line_buf.push_back(q);
    repeat (len) begin
      case ($urandom_range(0, 5))
        0: begin
          line_buf.push_back(ChBsl);
          line_buf.push_back(q);
        end
        1:       line_buf.push_back(any_char());
        default: line_buf.push_back(letter_char());
      endcase
    end
    line_buf.push_back(q);
  endtask

  task automatic compose_line();
    int unsigned parts;
    line_buf.delete();
    case ($urandom_range(0, 15))
      0: begin
        repeat ($urandom_range(1, 3)) line_buf.push_back(blank_char());
      end
      1, 2, 3: begin
        repeat ($urandom_range(1, 10)) line_buf.push_back(any_char());
      end
      default: begin
        parts = $urandom_range(1, 4);
        repeat (parts) begin
          case ($urandom_range(0, 5))
            0, 1: add_word();
            2:    add_quoted(ChDq);
            3:    add_quoted(ChSq);
            4:    line_buf.push_back(ChAmp);
            default: begin
              add_word();
              add_quoted(($urandom_range(0, 1) == 0) ? ChDq : ChSq);
            end
          endcase
          if ($urandom_range(0, 3) != 0) line_buf.push_back(blank_char());
        end
        if ($urandom_range(0, 7) == 0) begin
          line_buf.push_back(($urandom_range(0, 1) == 0) ? ChDq : ChSq);
        end
      end
    endcase
  endtask

  task automatic offer_byte(in_item_t it);
    int unsigned gap;
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    gap = (bytes_sent >= 120 && bytes_sent < 170) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_line();
    int unsigned i;
    in_item_t    it;
    for (i = 0; i < line_buf.size(); i++) begin
      it.byte_in  = line_buf[i];
      it.line_end = (i == line_buf.size() - 1);
      offer_byte(it);
    end
  endtask

  initial begin : make_stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme byte values, ampersands, an escaped blank and a blank-terminated line.
    line_buf = '{8'h01, 8'hFF, SpaceCh, ChAmp, LetterA, ChAmp, 8'h0B, ChBsl, SpaceCh,
                 8'h62, 8'h0D};
    send_line();
    // Escaped double quote, closed quotes and a single quote that ignores backslash.
    line_buf = '{ChDq, LetterA, ChBsl, ChDq, 8'h62, ChDq, ChSq, ChBsl, ChSq};
    send_line();
    // A backslash as the final byte of a word.
    line_buf = '{LetterA, ChBsl};
    send_line();
    // A quote as the final byte is unmatched at once.
    line_buf = '{ChDq};
    send_line();
    // An unterminated single-quoted token keeps its bytes before the error.
    line_buf = '{ChSq, LetterA};
    send_line();

    while (bytes_sent < ItemTarget) begin
      compose_line();
      send_line();
    end
    in_push <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : drain_results
    int unsigned gap;
    int unsigned popped;
    int unsigned hold_at;
    popped  = 0;
    hold_at = 30;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (popped == hold_at) begin
        out_pop <= 1'b0;
        repeat (80) @(posedge clk);
        hold_at = (hold_at == 30) ? 200 : 32'hFFFF_FFFF;
      end
      gap = (popped >= 100 && popped < 160) ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      popped++;
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
